@@ hw/rtl/kmb_pkg.sv @@
// kmb_pkg: sizes, codes and shared constants of the mini-batch k-means update block
// no dependencies; imported by the top level and by kmb_div
package kmb_pkg;

   localparam int MAX_CLUSTERS = 16;
   localparam int MAX_DIMS     = 16;
   localparam int MAX_BATCH    = 64;

   localparam int CW          = $clog2(MAX_CLUSTERS);
   localparam int DW          = $clog2(MAX_DIMS);
   localparam int PW          = $clog2(MAX_BATCH);
   localparam int CENT_DEPTH  = MAX_CLUSTERS * MAX_DIMS;
   localparam int CAW         = $clog2(CENT_DEPTH);
   localparam int BATCH_DEPTH = MAX_BATCH * MAX_DIMS;
   localparam int BAW         = $clog2(BATCH_DEPTH);
   localparam int LPW         = 11;

   localparam int COORD_W = 32;
   localparam int MAG_W   = COORD_W + 1;
   localparam int HALF_W  = MAG_W - 16;
   localparam int PROD_W  = 2 * HALF_W;
   localparam int ACC_W   = 2 * MAG_W + DW - 1;

   localparam int KREG_W  = 5;
   localparam int DREG_W  = 5;
   localparam int BREG_W  = 7;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 7;
   localparam int MODE_W  = 2;

   localparam logic [CSR_IW-1:0] CSR_NUM_CLUSTERS = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_NUM_DIMS     = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_BATCH_SIZE   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic KIND_MEMBER  = 1'b0;
   localparam logic KIND_READOUT = 1'b1;

   localparam logic [COORD_W-1:0] COUNT_MAX = {COORD_W{1'b1}};

endpackage

@@ hw/rtl/mini_batch_kmeans_update.sv @@
// mini_batch_kmeans_update: top level, sequencer, distance unit and stores
// depends on kmb_pkg, kmb_ram and kmb_div
//
// Centroid writes are taken straight from idle; a readout passes a read
// wait state and then the response transfer. A batch point coordinate is
// stored as it is accepted; the coordinate that completes a batch starts
// the batch run, during which req_ready is low. The E step works per point,
// centroid and coordinate (one 17x17 multiplier used three times per
// squared term), then compares per point and centroid; the M step divides
// per coordinate (serial divider, one quotient bit per cycle) after a count
// update per point; each membership is then sent as a response transfer.
// Centroids read as zero after reset through per-entry valid bits; no
// clearing pass is needed.
module mini_batch_kmeans_update (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kmb_pkg::CSR_IW-1:0]       csr_index,
   input  logic [kmb_pkg::CSR_DW-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [kmb_pkg::MODE_W-1:0]       req_mode,
   input  logic [kmb_pkg::CW-1:0]           req_cluster_sel,
   input  logic [kmb_pkg::DW-1:0]           req_dim_sel,
   input  logic signed [kmb_pkg::COORD_W-1:0] req_coord_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_kind,
   output logic [kmb_pkg::CW-1:0]           rsp_cluster_index,
   output logic signed [kmb_pkg::COORD_W-1:0] rsp_coord_out,
   output logic                             rsp_last
);
   import kmb_pkg::*;

   localparam int SW = 5;
   localparam logic [SW-1:0] S_IDLE    = 5'd0;
   localparam logic [SW-1:0] S_RD_WAIT = 5'd1;
   localparam logic [SW-1:0] S_RSP     = 5'd2;
   localparam logic [SW-1:0] S_E_RD    = 5'd3;
   localparam logic [SW-1:0] S_E_DIFF  = 5'd4;
   localparam logic [SW-1:0] S_E_M0    = 5'd5;
   localparam logic [SW-1:0] S_E_M1    = 5'd6;
   localparam logic [SW-1:0] S_E_M2    = 5'd7;
   localparam logic [SW-1:0] S_E_M3    = 5'd8;
   localparam logic [SW-1:0] S_E_CMP   = 5'd9;
   localparam logic [SW-1:0] S_M_ARD   = 5'd10;
   localparam logic [SW-1:0] S_M_AWAIT = 5'd11;
   localparam logic [SW-1:0] S_M_CNT   = 5'd12;
   localparam logic [SW-1:0] S_M_RD    = 5'd13;
   localparam logic [SW-1:0] S_M_DIFF  = 5'd14;
   localparam logic [SW-1:0] S_M_DIV   = 5'd15;
   localparam logic [SW-1:0] S_O_RD    = 5'd16;
   localparam logic [SW-1:0] S_O_WAIT  = 5'd17;

   logic [SW-1:0]     state_ff, state_in;
   logic [KREG_W-1:0] kreg_ff, kreg_in;
   logic [DREG_W-1:0] dreg_ff, dreg_in;
   logic [BREG_W-1:0] breg_ff, breg_in;
   logic [LPW-1:0]    lp_ff, lp_in;
   logic [PW-1:0]     p_ff, p_in;
   logic [CW-1:0]     c_ff, c_in;
   logic [DW-1:0]     j_ff, j_in;
   logic [BAW-1:0]    pbase_ff, pbase_in;
   logic [CW-1:0]     c2_ff, c2_in;
   logic [CW-1:0]     bidx_ff, bidx_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  best_ff, best_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_ff, neg_in;
   logic [COORD_W-1:0] cen_ff, cen_in;
   logic [COORD_W-1:0] counts_ff [MAX_CLUSTERS];
   logic [CENT_DEPTH-1:0] valid_ff;
   logic              cvalid_rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [CW-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [COORD_W-1:0] rsp_coord_ff, rsp_coord_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              cnt_we;
   logic [CW-1:0]     cnt_wa;
   logic [COORD_W-1:0] cnt_wd;

   logic              cent_we;
   logic [CAW-1:0]    cent_wa, cent_ra;
   logic [COORD_W-1:0] cent_wd, cent_rd;
   logic              bat_we;
   logic [BAW-1:0]    bat_wa, bat_ra;
   logic [COORD_W-1:0] bat_wd, bat_rd;
   logic              asg_we;
   logic [PW-1:0]     asg_wa, asg_ra;
   logic [CW-1:0]     asg_wd, asg_rd;

   logic              div_start, div_done;
   logic [MAG_W-1:0]  div_dividend, div_quo;

   logic [KREG_W-1:0] k_eff;
   logic [DREG_W-1:0] d_eff;
   logic [BREG_W-1:0] b_eff;
   logic [LPW-1:0]    lp_next;
   logic [COORD_W-1:0] cent_val;
   logic signed [MAG_W-1:0] diff;
   logic [HALF_W-1:0] mh, ml, opa, opb;
   logic              wins;
   logic [CW-1:0]     newbest;
   logic              j_last, c_last, p_last;
   logic signed [MAG_W:0] delta;
   logic signed [MAG_W:0] upd;

   always_comb begin
      k_eff = (kreg_ff == '0) ? KREG_W'(1) :
              (kreg_ff > KREG_W'(MAX_CLUSTERS)) ? KREG_W'(MAX_CLUSTERS) : kreg_ff;
      d_eff = (dreg_ff == '0) ? DREG_W'(1) :
              (dreg_ff > DREG_W'(MAX_DIMS)) ? DREG_W'(MAX_DIMS) : dreg_ff;
      b_eff = (breg_ff == '0) ? BREG_W'(1) :
              (breg_ff > BREG_W'(MAX_BATCH)) ? BREG_W'(MAX_BATCH) : breg_ff;
   end

   assign cent_val = cvalid_rd_ff ? cent_rd : '0;
   assign diff     = $signed({bat_rd[COORD_W-1], bat_rd}) -
                     $signed({cent_val[COORD_W-1], cent_val});
   assign mh       = mag_ff[MAG_W-1:16];
   assign ml       = {{(HALF_W-16){1'b0}}, mag_ff[15:0]};
   assign j_last   = {1'b0, j_ff} == (d_eff - DREG_W'(1));
   assign c_last   = {1'b0, c_ff} == (k_eff - KREG_W'(1));
   assign p_last   = {1'b0, p_ff} == (b_eff - BREG_W'(1));
   assign wins     = (c_ff == '0) || (acc_ff < best_ff);
   assign newbest  = wins ? c_ff : bidx_ff;
   assign lp_next  = lp_ff + LPW'(1);
   assign delta    = neg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
   assign upd      = $signed({{2{cen_ff[COORD_W-1]}}, cen_ff}) + delta;

   always_comb begin
      state_in     = state_ff;
      kreg_in      = kreg_ff;
      dreg_in      = dreg_ff;
      breg_in      = breg_ff;
      lp_in        = lp_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      j_in         = j_ff;
      pbase_in     = pbase_ff;
      c2_in        = c2_ff;
      bidx_in      = bidx_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      cen_in       = cen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_coord_in = rsp_coord_ff;
      rsp_last_in  = rsp_last_ff;
      cnt_we       = 1'b0;
      cnt_wa       = c2_ff;
      cnt_wd       = '0;
      cent_we      = 1'b0;
      cent_wa      = {c2_ff, j_ff};
      cent_wd      = upd[COORD_W-1:0];
      cent_ra      = {c_ff, j_ff};
      bat_we       = 1'b0;
      bat_wa       = lp_ff[BAW-1:0];
      bat_wd       = req_coord_value;
      bat_ra       = pbase_ff + BAW'(j_ff);
      asg_we       = 1'b0;
      asg_wa       = p_ff;
      asg_wd       = newbest;
      asg_ra       = p_ff;
      div_start    = 1'b0;
      div_dividend = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      opa          = mh;
      opb          = mh;

      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_CLUSTERS: kreg_in = csr_wdata[KREG_W-1:0];
            CSR_NUM_DIMS:     dreg_in = csr_wdata[DREG_W-1:0];
            CSR_BATCH_SIZE:   breg_in = csr_wdata[BREG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            cent_ra = {req_cluster_sel, req_dim_sel};
            if (req_valid) begin
               case (req_mode)
                  MODE_WRITE: begin
                     cent_we = 1'b1;
                     cent_wa = {req_cluster_sel, req_dim_sel};
                     cent_wd = req_coord_value;
                     cnt_we  = 1'b1;
                     cnt_wa  = req_cluster_sel;
                  end
                  MODE_READ: begin
                     rsp_idx_in = req_cluster_sel;
                     state_in   = S_RD_WAIT;
                  end
                  MODE_POINT: begin
                     bat_we = lp_ff < LPW'(BATCH_DEPTH);
                     if (lp_next >= LPW'(b_eff) * LPW'(d_eff)) begin
                        lp_in    = '0;
                        p_in     = '0;
                        c_in     = '0;
                        j_in     = '0;
                        pbase_in = '0;
                        acc_in   = '0;
                        state_in = S_E_RD;
                     end else begin
                        lp_in = lp_next;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_READOUT;
            rsp_coord_in = cent_val;
            rsp_last_in  = 1'b1;
            state_in     = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  p_in     = p_ff + PW'(1);
                  state_in = S_O_RD;
               end
            end
         end
         S_E_RD: state_in = S_E_DIFF;
         S_E_DIFF: begin
            mag_in   = div_dividend;
            state_in = S_E_M0;
         end
         S_E_M0: begin
            prod_in  = opa * opb;
            state_in = S_E_M1;
         end
         S_E_M1: begin
            opb      = ml;
            acc_in   = acc_ff + (ACC_W'(prod_ff) << 32);
            prod_in  = opa * opb;
            state_in = S_E_M2;
         end
         S_E_M2: begin
            opa      = ml;
            opb      = ml;
            acc_in   = acc_ff + (ACC_W'(prod_ff) << 17);
            prod_in  = opa * opb;
            state_in = S_E_M3;
         end
         S_E_M3: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (j_last) begin
               state_in = S_E_CMP;
            end else begin
               j_in     = j_ff + DW'(1);
               state_in = S_E_RD;
            end
         end
         S_E_CMP: begin
            if (wins) begin
               best_in = acc_ff;
            end
            bidx_in = newbest;
            j_in    = '0;
            acc_in  = '0;
            c_in    = c_ff + CW'(1);
            state_in = S_E_RD;
            if (c_last) begin
               asg_we = 1'b1;
               c_in   = '0;
               if (p_last) begin
                  p_in     = '0;
                  pbase_in = '0;
                  state_in = S_M_ARD;
               end else begin
                  p_in     = p_ff + PW'(1);
                  pbase_in = pbase_ff + BAW'(d_eff);
               end
            end
         end
         S_M_ARD: state_in = S_M_AWAIT;
         S_M_AWAIT: begin
            c2_in    = asg_rd;
            state_in = S_M_CNT;
         end
         S_M_CNT: begin
            cnt_we   = counts_ff[c2_ff] != COUNT_MAX;
            cnt_wd   = counts_ff[c2_ff] + COORD_W'(1);
            j_in     = '0;
            state_in = S_M_RD;
         end
         S_M_RD: begin
            cent_ra  = {c2_ff, j_ff};
            state_in = S_M_DIFF;
         end
         S_M_DIFF: begin
            neg_in    = diff[MAG_W-1];
            cen_in    = cent_val;
            div_start = 1'b1;
            state_in  = S_M_DIV;
         end
         S_M_DIV: begin
            if (div_done) begin
               cent_we = 1'b1;
               if (j_last) begin
                  if (p_last) begin
                     p_in     = '0;
                     state_in = S_O_RD;
                  end else begin
                     p_in     = p_ff + PW'(1);
                     pbase_in = pbase_ff + BAW'(d_eff);
                     state_in = S_M_ARD;
                  end
               end else begin
                  j_in     = j_ff + DW'(1);
                  state_in = S_M_RD;
               end
            end
         end
         S_O_RD: state_in = S_O_WAIT;
         S_O_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_MEMBER;
            rsp_idx_in   = asg_rd;
            rsp_coord_in = '0;
            rsp_last_in  = p_last;
            state_in     = S_RSP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kreg_ff      <= KREG_W'(MAX_CLUSTERS);
         dreg_ff      <= DREG_W'(MAX_DIMS);
         breg_ff      <= BREG_W'(MAX_BATCH);
         lp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         kreg_ff      <= kreg_in;
         dreg_ff      <= dreg_in;
         breg_ff      <= breg_in;
         lp_ff        <= lp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cent_we) begin
            valid_ff[cent_wa] <= 1'b1;
         end
         if (cnt_we) begin
            counts_ff[cnt_wa] <= cnt_wd;
         end
      end
      p_ff         <= p_in;
      c_ff         <= c_in;
      j_ff         <= j_in;
      pbase_ff     <= pbase_in;
      c2_ff        <= c2_in;
      bidx_ff      <= bidx_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      cen_ff       <= cen_in;
      cvalid_rd_ff <= valid_ff[cent_ra];
      rsp_kind_ff  <= rsp_kind_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_coord_ff <= rsp_coord_in;
      rsp_last_ff  <= rsp_last_in;
   end

   kmb_ram #(.WIDTH(COORD_W), .DEPTH(CENT_DEPTH)) u_cent_ram (
      .clock   (clock),
      .wr_en   (cent_we),
      .wr_addr (cent_wa),
      .wr_data (cent_wd),
      .rd_addr (cent_ra),
      .rd_data (cent_rd)
   );

   kmb_ram #(.WIDTH(COORD_W), .DEPTH(BATCH_DEPTH)) u_batch_ram (
      .clock   (clock),
      .wr_en   (bat_we),
      .wr_addr (bat_wa),
      .wr_data (bat_wd),
      .rd_addr (bat_ra),
      .rd_data (bat_rd)
   );

   kmb_ram #(.WIDTH(CW), .DEPTH(MAX_BATCH)) u_asg_ram (
      .clock   (clock),
      .wr_en   (asg_we),
      .wr_addr (asg_wa),
      .wr_data (asg_wd),
      .rd_addr (asg_ra),
      .rd_data (asg_rd)
   );

   kmb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (counts_ff[c2_ff]),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign csr_ready         = 1'b1;
   assign req_ready         = state_ff == S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_cluster_index = rsp_idx_ff;
   assign rsp_coord_out     = rsp_coord_ff;
   assign rsp_last          = rsp_last_ff;
endmodule

@@ hw/rtl/kmb_ram.sv @@
// kmb_ram: generic one-write one-read ram with registered read data
// no dependencies; used for the centroid, batch and assignment stores
module kmb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/kmb_div.sv @@
// kmb_div: restoring unsigned divider, one quotient bit per cycle
// depends on kmb_pkg for operand widths
module kmb_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [kmb_pkg::MAG_W-1:0]   dividend,
   input  logic [kmb_pkg::COORD_W-1:0] divisor,
   output logic                        done,
   output logic [kmb_pkg::MAG_W-1:0]   quotient
);
   import kmb_pkg::*;

   localparam int CNTW = $clog2(MAG_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [COORD_W-1:0] dvs_ff, dvs_in;
   logic [MAG_W-1:0]  trial;
   logic              fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[MAG_W-2:0], quo_ff[MAG_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(MAG_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, dvs_ff}) : trial;
         quo_in = {quo_ff[MAG_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
